### rtl/core/krre_pkg.sv
// Shared types and constants for the key record/replay block with edge detection.
// No dependencies; every module of the block imports this package.
package krre_pkg;

  localparam int unsigned KeyW   = 15;
  localparam int unsigned CountW = 11;
  localparam int unsigned Depth  = 1024;
  localparam int unsigned AddrW  = $clog2(Depth);

  localparam logic [CountW-1:0] DepthCnt = CountW'(Depth);

  typedef enum logic [1:0] {
    ActFrame    = 2'd0,
    ActRecStart = 2'd1,
    ActRecEnd   = 2'd2,
    ActPlay     = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ModeNormal = 2'd0,
    ModeRecord = 2'd1,
    ModePlay   = 2'd2
  } mode_e;

  // What the edge stage must do with the key vectors for one item.
  typedef enum logic [1:0] {
    KindHold = 2'd0,
    KindLive = 2'd1,
    KindPlay = 2'd2,
    KindZero = 2'd3
  } kind_e;

  typedef struct packed {
    logic [1:0]      action;
    logic [KeyW-1:0] keys_down;
  } in_t;

  typedef struct packed {
    logic [KeyW-1:0]   current_keys;
    logic [KeyW-1:0]   previous_keys;
    logic [KeyW-1:0]   pressed_edges;
    logic [KeyW-1:0]   released_edges;
    logic [1:0]        mode;
    logic [CountW-1:0] recorded_frames;
  } out_t;

  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] waddr;
    logic [KeyW-1:0]  wdata;
    logic             re;
    logic [AddrW-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    kind_e             kind;
    logic [KeyW-1:0]   keys;
    mode_e             mode;
    logic [CountW-1:0] count;
  } stage_t;

endpackage

### rtl/core/krre_store.sv
// Frame store: single-port-write, single-port-read memory with registered read data.
// Depends on krre_pkg for the request type and sizes.
module krre_store import krre_pkg::*; (
  input  logic            clk_i,
  input  mem_req_t        mem_req_i,
  output logic [KeyW-1:0] rdata_o
);

  logic [KeyW-1:0] mem [Depth];
  logic [KeyW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (mem_req_i.we) begin
      mem[mem_req_i.waddr] <= mem_req_i.wdata;
    end
    if (mem_req_i.re) begin
      rdata_q <= mem[mem_req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/krre_ctrl.sv
// Front stage: mode, frame count and play index; issues frame store reads and writes.
// Depends on krre_pkg.
module krre_ctrl import krre_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  in_t               in_data_i,
  input  logic [CountW-1:0] limit_i,
  output logic              stg_valid_o,
  input  logic              stg_ready_i,
  output stage_t            stg_o,
  output mem_req_t          mem_req_o
);

  mode_e             mode_q, mode_d;
  logic [CountW-1:0] count_q, count_d;
  logic [CountW-1:0] idx_q, idx_d;
  logic [CountW-1:0] eff_limit;
  logic              stg_valid_q;
  stage_t            stg_q;
  kind_e             kind;
  logic              accept;
  mem_req_t          req;

  assign in_ready_o = !stg_valid_q || stg_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign eff_limit  = (limit_i > DepthCnt) ? DepthCnt : limit_i;

  always_comb begin
    mode_d    = mode_q;
    count_d   = count_q;
    idx_d     = idx_q;
    kind      = KindHold;
    req.we    = 1'b0;
    req.waddr = count_q[AddrW-1:0];
    req.wdata = in_data_i.keys_down;
    req.re    = 1'b0;
    req.raddr = idx_q[AddrW-1:0];
    unique case (action_e'(in_data_i.action))
      ActFrame: begin
        if (mode_q == ModePlay) begin
          if (idx_q >= count_q || idx_q >= DepthCnt) begin
            kind   = KindZero;
            mode_d = ModeNormal;
          end else begin
            kind   = KindPlay;
            req.re = 1'b1;
            idx_d  = idx_q + CountW'(1);
          end
        end else begin
          kind = KindLive;
          if (mode_q == ModeRecord && count_q < eff_limit) begin
            req.we  = 1'b1;
            count_d = count_q + CountW'(1);
          end
        end
      end
      ActRecStart: begin
        mode_d  = ModeRecord;
        count_d = '0;
      end
      ActRecEnd: begin
        mode_d = ModeNormal;
      end
      ActPlay: begin
        mode_d = ModePlay;
        idx_d  = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= ModeNormal;
      count_q     <= '0;
      idx_q       <= '0;
      stg_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        mode_q  <= mode_d;
        count_q <= count_d;
        idx_q   <= idx_d;
      end
      if (accept) begin
        stg_valid_q <= 1'b1;
      end else if (stg_ready_i) begin
        stg_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      stg_q.kind  <= kind;
      stg_q.keys  <= in_data_i.keys_down;
      stg_q.mode  <= mode_d;
      stg_q.count <= count_d;
    end
  end

  assign mem_req_o.we    = req.we && accept;
  assign mem_req_o.waddr = req.waddr;
  assign mem_req_o.wdata = req.wdata;
  assign mem_req_o.re    = req.re && accept;
  assign mem_req_o.raddr = req.raddr;

  assign stg_valid_o = stg_valid_q;
  assign stg_o       = stg_q;

  // Playback never reads past the recorded frames.
  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q == ModePlay |-> idx_q <= count_q)
    else $error("play index beyond frame count");

  a_count_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DepthCnt)
    else $error("frame count beyond store depth");

  // A write always lands below the effective limit and advances the count.
  a_write_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_req_o.we |=> count_q == $past(count_q) + CountW'(1))
    else $error("store write without count advance");

  a_one_access: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_req_o.we && mem_req_o.re))
    else $error("read and write issued for one item");

endmodule

### rtl/core/krre_edge.sv
// Back stage: updates current/previous key vectors and edges, holds the result register.
// Depends on krre_pkg; takes the registered read data of krre_store.
module krre_edge import krre_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            stg_valid_i,
  output logic            stg_ready_o,
  input  stage_t          stg_i,
  input  logic [KeyW-1:0] rdata_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output out_t            out_data_o
);

  logic [KeyW-1:0]   now_q, last_q, rise_q, fall_q;
  logic [KeyW-1:0]   next_keys;
  logic [CountW-1:0] count_q;
  logic [1:0]        mode_q;
  logic              out_valid_q;
  logic              take;

  assign stg_ready_o = !out_valid_q || out_ready_i;
  assign take        = stg_valid_i && stg_ready_o;

  always_comb begin
    unique case (stg_i.kind)
      KindLive: next_keys = stg_i.keys;
      KindPlay: next_keys = rdata_i;
      KindZero: next_keys = '0;
      default:  next_keys = now_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      now_q       <= '0;
      last_q      <= '0;
      rise_q      <= '0;
      fall_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (take && stg_i.kind != KindHold) begin
        last_q <= now_q;
        now_q  <= next_keys;
        rise_q <= next_keys & ~now_q;
        fall_q <= now_q & ~next_keys;
      end
      if (take) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      mode_q  <= stg_i.mode;
      count_q <= stg_i.count;
    end
  end

  assign out_valid_o                = out_valid_q;
  assign out_data_o.current_keys    = now_q;
  assign out_data_o.previous_keys   = last_q;
  assign out_data_o.pressed_edges   = rise_q;
  assign out_data_o.released_edges  = fall_q;
  assign out_data_o.mode            = mode_q;
  assign out_data_o.recorded_frames = count_q;

  a_edges_disjoint: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rise_q & fall_q) == '0)
    else $error("key both pressed and released");

  // A command beat leaves the vectors untouched.
  a_hold_keeps_keys: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && stg_i.kind == KindHold |=> now_q == $past(now_q) && last_q == $past(last_q))
    else $error("command changed key vectors");

endmodule

### rtl/core/key_record_replay_edges_top.sv
// Top level of the key record/replay block with press and release edge detection.
// Depends on krre_pkg, krre_ctrl, krre_store and krre_edge.
//
// Each input beat is either a frame carrying the live key vector or a command
// (start recording, end recording, start playback), and each input beat yields
// exactly one result beat with the current and previous key vectors, the press
// and release edges, the mode after the beat and the number of recorded frames.
// The block sustains one beat per clock cycle while the output is not stalled.
// From input acceptance to result valid, the front stage updates the mode and
// counters and issues at most one access to the 1024-entry frame store; the
// back stage picks up the registered read data and forms the edges. A new beat
// enters an empty front stage while a result waits at the output. A recorded
// frame is written at its acceptance edge and playback can begin only after a
// start-playback command, so a read never overlaps a pending write to the same
// entry. The record limit is written through its own port, which is always
// ready; write it only while the block is idle. Limits above the store depth
// act as the depth. Stored frames have no reset and are only read back after
// being recorded.
module key_record_replay_edges_top import krre_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [CountW-1:0] cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  in_t               in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output out_t              out_data_o
);

  logic [CountW-1:0] limit_q;
  logic              stg_valid;
  logic              stg_ready;
  stage_t            stg;
  mem_req_t          mem_req;
  logic [KeyW-1:0]   rdata;

  // The record limit register takes a beat every cycle.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= '0;
    end else if (cfg_valid_i) begin
      limit_q <= cfg_data_i;
    end
  end

  krre_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .limit_i     (limit_q),
    .stg_valid_o (stg_valid),
    .stg_ready_i (stg_ready),
    .stg_o       (stg),
    .mem_req_o   (mem_req)
  );

  krre_store u_store (
    .clk_i     (clk_i),
    .mem_req_i (mem_req),
    .rdata_o   (rdata)
  );

  krre_edge u_edge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .stg_valid_i (stg_valid),
    .stg_ready_o (stg_ready),
    .stg_i       (stg),
    .rdata_i     (rdata),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
